>>> sv/mre_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mre_pkg
// Types, constants and helper functions shared by the rewrite engine files.
// ----------------------------------------------------------------------------
package mre_pkg;

  localparam int MAX_RULES  = 16;
  localparam int STEP_LIMIT = 1024;
  localparam int WORD_W     = 64;
  localparam int RIDX_W     = $clog2(MAX_RULES);

  localparam logic       OP_WRITE = 1'b0;
  localparam logic       OP_RUN   = 1'b1;
  localparam logic [1:0] REG_BPL  = 2'd0;
  localparam logic [1:0] REG_RULE_COUNT = 2'd1;

  typedef enum logic [1:0] {
    RS_NO_MATCH = 2'd0,
    RS_TERMINAL = 2'd1,
    RS_TIMEOUT  = 2'd2
  } run_status_t;

  typedef struct packed {
    logic        operation;
    logic [3:0]  rule_index;
    logic [31:0] pattern_word;
    logic [5:0]  pattern_letters;
    logic [31:0] replacement_word;
    logic [5:0]  replacement_letters;
    logic        terminal;
    logic [63:0] start_word;
    logic [6:0]  start_length;
  } in_data_t;

  typedef struct packed {
    logic [63:0] final_word;
    logic [6:0]  final_length;
    logic [15:0] step_count;
    logic [1:0]  run_status;
  } out_data_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_INIT, ST_CHECK, ST_READ, ST_SETUP,
    ST_SCAN, ST_FIRE, ST_SPLICE, ST_DONE
  } state_t;

  typedef struct packed {
    logic        wr_rule;
    logic        start;
    logic        run_init;
    logic        step_init;
    logic        rd_rule;
    logic        next_rule;
    logic        setup;
    logic        advance;
    logic        fire;
    logic        commit;
    logic        finish;
    logic [1:0]  finish_code;
    logic        load_out;
  } cmd_t;

  typedef struct packed {
    logic bpl_zero;
    logic too_long;
    logic limit_hit;
    logic rules_done;
    logic plen_bad;
    logic pos_ok;
    logic hit;
    logic term;
    logic overflow;
    logic out_free;
  } sts_t;

  // ones in the low n bits, all ones at 64 or more
  function automatic logic [63:0] low_mask(input logic [10:0] n);
    low_mask = ~({64{1'b1}} << n);
  endfunction

  // letters that fit in the word for a given letter size
  function automatic logic [6:0] capacity(input logic [3:0] bpl);
    case (bpl)
      4'd1:    capacity = 7'd64;
      4'd2:    capacity = 7'd32;
      4'd3:    capacity = 7'd21;
      4'd4:    capacity = 7'd16;
      4'd5:    capacity = 7'd12;
      4'd6:    capacity = 7'd10;
      4'd7:    capacity = 7'd9;
      4'd8:    capacity = 7'd8;
      4'd9:    capacity = 7'd7;
      4'd10:   capacity = 7'd6;
      4'd11:   capacity = 7'd5;
      4'd12:   capacity = 7'd5;
      default: capacity = 7'd4;
    endcase
  endfunction

endpackage

>>> sv/mre_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mre_ctrl
// Sequencer for rule writes and rewrite runs; drives the datapath by commands.
// ----------------------------------------------------------------------------
module mre_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_op,
  output logic          in_ready,
  input  mre_pkg::sts_t sts,
  output mre_pkg::cmd_t cmd
);
  import mre_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = (state_r == ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_op == OP_WRITE) begin
          cmd.wr_rule = 1'b1;
        end else if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = ST_INIT;
        end
      end
      ST_INIT: begin
        if (sts.bpl_zero) begin
          cmd.finish = 1'b1;
          cmd.finish_code = RS_NO_MATCH;
          state_nxt = ST_DONE;
        end else if (sts.too_long) begin
          cmd.finish = 1'b1;
          cmd.finish_code = RS_TIMEOUT;
          state_nxt = ST_DONE;
        end else begin
          cmd.run_init = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.limit_hit) begin
          cmd.finish = 1'b1;
          cmd.finish_code = RS_TIMEOUT;
          state_nxt = ST_DONE;
        end else begin
          cmd.step_init = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (sts.rules_done) begin
          cmd.finish = 1'b1;
          cmd.finish_code = RS_NO_MATCH;
          state_nxt = ST_DONE;
        end else begin
          cmd.rd_rule = 1'b1;
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (sts.plen_bad) begin
          cmd.next_rule = 1'b1;
          state_nxt = ST_READ;
        end else begin
          cmd.setup = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!sts.pos_ok) begin
          cmd.next_rule = 1'b1;
          state_nxt = ST_READ;
        end else if (sts.hit) begin
          state_nxt = ST_FIRE;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      ST_FIRE: begin
        cmd.fire = 1'b1;
        if (sts.term) begin
          cmd.finish = 1'b1;
          cmd.finish_code = RS_TERMINAL;
          state_nxt = ST_DONE;
        end else if (sts.overflow) begin
          cmd.finish = 1'b1;
          cmd.finish_code = RS_TIMEOUT;
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_SPLICE;
        end
      end
      ST_SPLICE: begin
        cmd.commit = 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> sv/mre_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mre_dp
// Rule memory, word registers, position scanner, splice unit and result
// register of the rewrite engine.
// ----------------------------------------------------------------------------
module mre_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_addr,
  input  logic [4:0]        cfg_wdata,
  input  mre_pkg::in_data_t in_data,
  input  mre_pkg::cmd_t     cmd,
  output mre_pkg::sts_t     sts,
  input  logic              out_ready,
  output logic              out_valid,
  output mre_pkg::out_data_t out_data
);
  import mre_pkg::*;

  // rule memory
  logic [31:0] pat_mem [MAX_RULES];
  logic [5:0]  plen_mem [MAX_RULES];
  logic [31:0] rep_mem [MAX_RULES];
  logic [5:0]  rlen_mem [MAX_RULES];
  logic        term_mem [MAX_RULES];

  logic [31:0] rd_pat_r;
  logic [5:0]  rd_plen_r;
  logic [31:0] rd_rep_r;
  logic [5:0]  rd_rlen_r;
  logic        rd_term_r;

  logic [3:0]  bpl_r;
  logic [4:0]  count_r;
  logic [4:0]  nrules;

  logic [63:0] word_r, word_nxt;
  logic [6:0]  len_r, len_nxt;
  logic [15:0] steps_r;
  logic [1:0]  status_r;
  logic [4:0]  k_r;

  logic [63:0] mask_r, patm_r, sw_r;
  logic [9:0]  plb_r;
  logic [6:0]  pos_r;
  logic [10:0] sh_r;

  logic [63:0] tail_r, low_r, repm_r;
  logic [10:0] sh2_r;
  logic [6:0]  nlen_r;

  logic [6:0]  cap;
  logic [9:0]  plb;
  logic [63:0] pmask;
  logic [7:0]  nlen;
  logic [10:0] cut;
  logic [10:0] rb;
  logic [63:0] spliced;

  logic        out_valid_r;
  out_data_t   out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpl_r   <= 4'd1;
      count_r <= 5'd0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_BPL:        bpl_r   <= cfg_wdata[3:0];
        REG_RULE_COUNT: count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign nrules = (count_r > 5'(MAX_RULES)) ? 5'(MAX_RULES) : count_r;
  assign cap    = capacity(bpl_r);

  always_ff @(posedge clk) begin
    if (cmd.wr_rule) begin
      pat_mem[in_data.rule_index]  <= in_data.pattern_word;
      plen_mem[in_data.rule_index] <= in_data.pattern_letters;
      rep_mem[in_data.rule_index]  <= in_data.replacement_word;
      rlen_mem[in_data.rule_index] <= in_data.replacement_letters;
      term_mem[in_data.rule_index] <= in_data.terminal;
    end
    if (cmd.rd_rule) begin
      rd_pat_r  <= pat_mem[k_r[RIDX_W-1:0]];
      rd_plen_r <= plen_mem[k_r[RIDX_W-1:0]];
      rd_rep_r  <= rep_mem[k_r[RIDX_W-1:0]];
      rd_rlen_r <= rlen_mem[k_r[RIDX_W-1:0]];
      rd_term_r <= term_mem[k_r[RIDX_W-1:0]];
    end
  end

  assign plb   = 10'(rd_plen_r * bpl_r);
  assign pmask = low_mask({1'b0, plb});
  assign nlen  = 8'(len_r) - 8'(rd_plen_r) + 8'(rd_rlen_r);
  assign cut   = sh_r + 11'(plb_r);
  assign rb    = 11'(rd_rlen_r * bpl_r);

  assign spliced = low_r | (repm_r << sh_r) | (tail_r << sh2_r);

  always_comb begin
    word_nxt = word_r;
    len_nxt  = len_r;
    if (cmd.start) begin
      word_nxt = in_data.start_word;
      len_nxt  = in_data.start_length;
    end else if (cmd.run_init) begin
      word_nxt = word_r & low_mask(11'(len_r * bpl_r));
    end else if (cmd.commit) begin
      word_nxt = spliced & low_mask(11'(nlen_r * bpl_r));
      len_nxt  = nlen_r;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    len_r  <= len_nxt;
    if (cmd.start)     steps_r  <= '0;
    if (cmd.fire)      steps_r  <= steps_r + 16'd1;
    if (cmd.finish)    status_r <= cmd.finish_code;
    if (cmd.step_init) k_r      <= '0;
    if (cmd.next_rule) k_r      <= k_r + 5'd1;
    if (cmd.setup) begin
      mask_r <= pmask;
      patm_r <= {32'd0, rd_pat_r} & pmask;
      plb_r  <= plb;
      sw_r   <= word_r;
      pos_r  <= '0;
      sh_r   <= '0;
    end else if (cmd.advance) begin
      sw_r  <= sw_r >> bpl_r;
      pos_r <= pos_r + 7'd1;
      sh_r  <= sh_r + 11'(bpl_r);
    end
    if (cmd.fire) begin
      // split the word around the match
      tail_r <= word_r >> cut;
      low_r  <= word_r & low_mask(sh_r);
      repm_r <= {32'd0, rd_rep_r} & low_mask(rb);
      sh2_r  <= sh_r + rb;
      nlen_r <= nlen[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r.final_word   <= word_r;
      out_data_r.final_length <= len_r;
      out_data_r.step_count   <= steps_r;
      out_data_r.run_status   <= status_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    sts.bpl_zero   = (bpl_r == 4'd0);
    sts.too_long   = (len_r > cap);
    sts.limit_hit  = (steps_r >= 16'(STEP_LIMIT));
    sts.rules_done = (k_r >= nrules);
    sts.plen_bad   = (rd_plen_r == 6'd0) || (7'(rd_plen_r) > len_r);
    sts.pos_ok     = ((8'(pos_r) + 8'(plb_r == 10'd0 ? 6'd0 : rd_plen_r)) <= 8'(len_r))
                     && (sh_r < 11'(WORD_W));
    sts.hit        = ((sw_r & mask_r) == patm_r);
    sts.term       = rd_term_r;
    sts.overflow   = (nlen > 8'(cap));
    sts.out_free   = !out_valid_r || out_ready;
  end

endmodule

>>> sv/markov_rewrite_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// markov_rewrite_engine
// Markov-algorithm string rewriter with a 16-entry rule table.
// ----------------------------------------------------------------------------
// A run sets up and then, in each rewrite step, reads and sets up each rule
// tried, scans the word for each rule whose pattern is checked, and fires and
// splices a rule that matches; the position scanner compares one position per
// cycle. One run is in flight at a time; the result waits in an output
// register so the next request can be taken while it is pending.
module markov_rewrite_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mre_pkg::in_data_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mre_pkg::out_data_t  out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_addr,
  input  logic [4:0]          cfg_wdata
);
  import mre_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mre_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.operation),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mre_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.operation == OP_RUN |=> !in_ready)
    else $error("run request did not make the engine busy");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.step_count <= 16'(STEP_LIMIT))
    else $error("step count beyond limit");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.run_status != 2'd3)
    else $error("undefined run status");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !out_valid || out_ready)
    else $error("result overwritten before taken");
`endif

endmodule

>>> bench/rewrite_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rewrite_checker
// Watches the request, result and register ports of the rewrite engine,
// keeps its own copy of the rule table and registers, works out the result
// of every run request and compares each result, field by field, in order.
// ----------------------------------------------------------------------------
module rewrite_checker
  import mre_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  in_data_t   in_data,
  input  logic       out_valid,
  input  logic       out_ready,
  input  out_data_t  out_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_addr,
  input  logic [4:0] cfg_wdata,
  output int         fail_count,
  output int         pending
);

  logic [31:0] rule_pat   [MAX_RULES];
  logic [5:0]  rule_plen  [MAX_RULES];
  logic [31:0] rule_rep   [MAX_RULES];
  logic [5:0]  rule_rlen  [MAX_RULES];
  logic        rule_term  [MAX_RULES];
  logic [3:0]  letter_bits;
  logic [4:0]  active_rules;
  out_data_t   expected_runs[$];

  function automatic logic [63:0] ones_below(int n);
    if (n >= 64) return {64{1'b1}};
    return (64'd1 << n) - 64'd1;
  endfunction

  function automatic int find_leftmost(logic [63:0] w, int len, logic [31:0] p,
                                       int plen, int bpl);
    logic [63:0] m;
    logic [63:0] pp;
    int sh;
    if (plen == 0 || plen > len) return -1;
    m  = ones_below(plen * bpl);
    pp = {32'd0, p} & m;
    for (int pos = 0; pos + plen <= len; pos++) begin
      sh = pos * bpl;
      if (sh >= 64) break;
      if (((w >> sh) & m) == pp) return pos;
    end
    return -1;
  endfunction

  function automatic logic [63:0] substitute(logic [63:0] w, int pos, int plen,
                                             logic [31:0] rep, int rlen, int bpl);
    int pb;
    int cut;
    int rb;
    logic [63:0] o;
    logic [63:0] tail;
    logic [63:0] r;
    pb   = pos * bpl;
    cut  = pb + plen * bpl;
    rb   = rlen * bpl;
    o    = w & ones_below(pb);
    tail = (cut >= 64) ? 64'd0 : (w >> cut);
    r    = {32'd0, rep} & ones_below(rb);
    if (pb < 64) o |= r << pb;
    if (pb + rb < 64) o |= tail << (pb + rb);
    return o;
  endfunction

  function automatic out_data_t rewrite_word(in_data_t req);
    int bpl;
    int nrules;
    int len;
    int cap;
    int steps;
    int pos;
    int nlen;
    bit fired;
    bit done;
    logic [63:0] w;
    run_status_t st;
    out_data_t res;
    bpl    = letter_bits;
    nrules = (active_rules > MAX_RULES) ? MAX_RULES : active_rules;
    w      = req.start_word;
    len    = req.start_length;
    steps  = 0;
    st     = RS_NO_MATCH;
    if (bpl != 0) begin
      cap = 64 / bpl;
      if (len > cap) begin
        st = RS_TIMEOUT;
      end else begin
        w &= ones_below(len * bpl);
        forever begin
          fired = 0;
          done  = 0;
          if (steps >= STEP_LIMIT) begin
            st = RS_TIMEOUT;
            break;
          end
          for (int k = 0; k < nrules; k++) begin
            pos = find_leftmost(w, len, rule_pat[k], rule_plen[k], bpl);
            if (pos < 0) continue;
            steps++;
            if (rule_term[k]) begin
              st   = RS_TERMINAL;
              done = 1;
              break;
            end
            nlen = len - rule_plen[k] + rule_rlen[k];
            if (nlen > cap) begin
              st   = RS_TIMEOUT;
              done = 1;
              break;
            end
            w     = substitute(w, pos, rule_plen[k], rule_rep[k], rule_rlen[k], bpl);
            len   = nlen;
            w    &= ones_below(len * bpl);
            fired = 1;
            break;
          end
          if (done) break;
          if (!fired) begin
            st = RS_NO_MATCH;
            break;
          end
        end
      end
    end
    res.final_word   = w;
    res.final_length = len[6:0];
    res.step_count   = steps[15:0];
    res.run_status   = st;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: mismatch in %s: got %h, want %h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    out_data_t want;
    if (!rst_n) begin
      letter_bits  <= 4'd1;
      active_rules <= 5'd0;
      expected_runs.delete();
      fail_count   = 0;
      pending      <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr == REG_BPL) letter_bits <= cfg_wdata[3:0];
        else if (cfg_addr == REG_RULE_COUNT) active_rules <= cfg_wdata;
      end
      if (in_valid && in_ready) begin
        if (in_data.operation == OP_WRITE) begin
          rule_pat[in_data.rule_index]  <= in_data.pattern_word;
          rule_plen[in_data.rule_index] <= in_data.pattern_letters;
          rule_rep[in_data.rule_index]  <= in_data.replacement_word;
          rule_rlen[in_data.rule_index] <= in_data.replacement_letters;
          rule_term[in_data.rule_index] <= in_data.terminal;
        end else begin
          expected_runs.push_back(rewrite_word(in_data));
        end
      end
      if (out_valid && out_ready) begin
        if (expected_runs.size() == 0) begin
          $display("%0t: result with no run request waiting", $realtime);
          fail_count++;
        end else begin
          want = expected_runs.pop_front();
          if (out_data.final_word !== want.final_word)
            report_mismatch("final_word", out_data.final_word, want.final_word);
          if (out_data.final_length !== want.final_length)
            report_mismatch("final_length", out_data.final_length, want.final_length);
          if (out_data.step_count !== want.step_count)
            report_mismatch("step_count", out_data.step_count, want.step_count);
          if (out_data.run_status !== want.run_status)
            report_mismatch("run_status", out_data.run_status, want.run_status);
        end
      end
      pending <= expected_runs.size();
    end
  end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives rule writes and run requests into the rewrite engine under changing
// letter sizes and rule counts, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb;
  import mre_pkg::*;

  localparam int WATCHDOG_LIMIT = 10000000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_data_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_data_t  out_data;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_addr = REG_BPL;
  logic [4:0] cfg_wdata = '0;
  int         fail_count;
  int         pending;
  int         tx_idle_pct = 0;
  int         rx_idle_pct = 0;
  int         hold_cnt = 0;
  bit         hold_req = 0;
  int         quiet_cycles = 0;
  int         cur_bpl = 1;

  always #5 clk = ~clk;

  markov_rewrite_engine dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  rewrite_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  // result side: random stalls, plus a long hold-off on demand
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 0;
      hold_cnt <= 600;
      out_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic in_data_t noise_item();
    logic [159:0] r;
    r = {$urandom, $urandom, $urandom, $urandom, $urandom};
    return in_data_t'(r[$bits(in_data_t)-1:0]);
  endfunction

  task automatic send(in_data_t item);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  task automatic write_rule(int idx, logic [31:0] pat, int plen, logic [31:0] rep,
                            int rlen, bit term);
    in_data_t it;
    it = noise_item();
    it.operation           = OP_WRITE;
    it.rule_index          = idx[3:0];
    it.pattern_word        = pat;
    it.pattern_letters     = plen[5:0];
    it.replacement_word    = rep;
    it.replacement_letters = rlen[5:0];
    it.terminal            = term;
    send(it);
  endtask

  task automatic run_word(logic [63:0] w, int len);
    in_data_t it;
    it = noise_item();
    it.operation    = OP_RUN;
    it.start_word   = w;
    it.start_length = len[6:0];
    send(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_reg(logic [1:0] addr, int val);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= val[4:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    if (addr == REG_BPL) cur_bpl = val;
  endtask

  // letters drawn from a small alphabet so patterns actually hit
  function automatic logic [63:0] fill_letters(logic [63:0] base, int n, int bpl);
    int amax;
    logic [63:0] w;
    w = base;
    if (bpl == 0) return w;
    amax = (bpl == 1) ? 1 : 3;
    for (int i = 0; i < n && i * bpl < 64; i++)
      for (int b = 0; b < bpl && i * bpl + b < 64; b++)
        w[i * bpl + b] = (b < 2) ? 1'((($urandom_range(0, amax)) >> b) & 1) : 1'b0;
    return w;
  endfunction

  task automatic random_rule(int idx);
    int plen;
    int rlen;
    int sel;
    int bpl;
    bpl  = (cur_bpl == 0) ? 1 : cur_bpl;
    plen = $urandom_range(0, 19) == 0 ? $urandom_range(0, 63) : $urandom_range(1, 3);
    sel  = $urandom_range(0, 19);
    // same-length rewrites are rare since they tend to loop to the step limit
    if (sel == 0) rlen = plen;
    else if (sel < 7) rlen = 0;
    else if (sel < 13 && plen > 0) rlen = plen - 1;
    else rlen = plen + 1;
    if (rlen > 63) rlen = 63;
    write_rule(idx, 32'(fill_letters({$urandom, $urandom}, plen, bpl)),
               plen, 32'(fill_letters({$urandom, $urandom}, rlen, bpl)), rlen,
               $urandom_range(0, 9) == 0);
  endtask

  task automatic random_run();
    int cap;
    int len;
    int top;
    cap = (cur_bpl == 0) ? 64 : 64 / cur_bpl;
    top = (cap < 12) ? cap : 12;
    if ($urandom_range(0, 9) == 0) len = $urandom_range(0, (cap + 3 > 127) ? 127 : cap + 3);
    else len = $urandom_range(0, top);
    run_word(fill_letters({$urandom, $urandom}, len, cur_bpl), len);
  endtask

  task automatic episode();
    int r;
    r = $urandom_range(0, 19);
    drain();
    if (r == 0) set_reg(REG_BPL, 0);
    else if (r < 3) set_reg(REG_BPL, $urandom_range(9, 15));
    else set_reg(REG_BPL, $urandom_range(1, 8));
    set_reg(REG_RULE_COUNT, $urandom_range(0, 9) == 0 ? $urandom_range(0, 31)
                                                      : $urandom_range(1, 6));
    repeat (4) random_rule($urandom_range(0, 15));
    repeat (15) random_run();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty rule set, then a start word longer than any capacity
    run_word({64{1'b1}}, 64);
    run_word({64{1'b1}}, 127);
    write_rule(0, 32'h0, 0, 32'h7, 3, 0);
    write_rule(1, 32'hFFFF_FFFF, 32, 32'h0, 0, 0);
    write_rule(2, 32'hFFFF_FFFF, 40, 32'hFFFF_FFFF, 33, 0);
    write_rule(3, 32'h2, 2, 32'h0, 1, 0);
    write_rule(4, 32'h7, 3, 32'h0, 0, 1);
    write_rule(5, 32'hFFFF_FFFF, 63, 32'hFFFF_FFFF, 63, 0);
    cur_bpl = 1;
    for (int i = 6; i < MAX_RULES; i++) random_rule(i);
    drain();
    set_reg(REG_RULE_COUNT, 16);
    run_word({64{1'b1}}, 64);
    run_word({$urandom, $urandom}, 40);
    run_word(64'h0123_4567_89AB_CDEF, 63);
    drain();
    set_reg(REG_RULE_COUNT, 31);
    run_word({$urandom, $urandom}, 20);
    drain();
    set_reg(REG_BPL, 0);
    run_word({$urandom, $urandom}, 33);
    drain();
    set_reg(REG_BPL, 15);
    run_word({$urandom, $urandom}, 4);
    run_word({$urandom, $urandom}, 5);
    drain();
    set_reg(REG_BPL, 8);
    run_word({$urandom, $urandom}, 8);
    drain();
    // step limit, overflowing replacement and a terminal rule, one rule each
    set_reg(REG_BPL, 1);
    set_reg(REG_RULE_COUNT, 1);
    write_rule(0, 32'h1, 1, 32'h1, 1, 0);
    run_word(64'h1, 1);
    write_rule(0, 32'h1, 1, 32'h3, 2, 0);
    run_word({64{1'b1}}, 60);
    write_rule(0, 32'h1, 1, 32'h0, 0, 1);
    run_word(64'h5, 3);
    drain();

    // receiver holds off while requests keep coming, then the sender waits it out
    hold_req = 1;
    repeat (8) random_run();
    drain();

    tx_idle_pct = 21; rx_idle_pct = 88;
    repeat (12) episode();
    tx_idle_pct = 88; rx_idle_pct = 21;
    repeat (12) episode();
    tx_idle_pct = 0;  rx_idle_pct = 0;
    repeat (12) episode();
    drain();
    repeat (50) @(posedge clk);

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
